FILE: rtl/core/lmfs_pkg.sv
`timescale 1ns / 1ps
package lmfs_pkg;

  localparam int POS_W      = 5;
  localparam int MASK_W     = 16;
  localparam int ROW_W      = 4;
  localparam int TAIL_EXTRA = 3;
  localparam logic [ROW_W-1:0] LAST_ROW = 4'd15;

  localparam logic [1:0] KIND_SCAN    = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_SPAWN   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] column;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    logic [MASK_W-1:0] column_mask;
    logic              frame_end;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WORK,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic work;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       last_col;
    logic       out_free;
  } status_t;

endpackage

FILE: rtl/core/lmfs_ram.sv
`timescale 1ns / 1ps
module lmfs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/lmfs_ctrl.sv
`timescale 1ns / 1ps
module lmfs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  lmfs_pkg::status_t status,
  output lmfs_pkg::cmd_t    cmd
);
  lmfs_pkg::state_t state;
  lmfs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lmfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      lmfs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lmfs_pkg::S_READ;
        end
      end
      lmfs_pkg::S_READ: begin
        // unused kind: drop without touching the store
        if (!(status.kind inside {lmfs_pkg::KIND_SCAN, lmfs_pkg::KIND_ADVANCE,
                                  lmfs_pkg::KIND_SPAWN})) begin
          state_next = lmfs_pkg::S_IDLE;
        end else begin
          state_next = lmfs_pkg::S_WORK;
        end
      end
      lmfs_pkg::S_WORK: begin
        cmd.work = 1'b1;
        if (status.kind == lmfs_pkg::KIND_SPAWN || status.last_col) begin
          if (status.kind == lmfs_pkg::KIND_SCAN) begin
            state_next = lmfs_pkg::S_FINISH;
          end else begin
            state_next = lmfs_pkg::S_IDLE;
          end
        end else begin
          cmd.step   = 1'b1;
          state_next = lmfs_pkg::S_READ;
        end
      end
      lmfs_pkg::S_FINISH: begin
        // hold until the output register can take the transfer
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = lmfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lmfs_pkg::S_IDLE;
      end
    endcase
  end
endmodule

FILE: rtl/core/lmfs_datapath.sv
`timescale 1ns / 1ps
module lmfs_datapath #(
  parameter int STREAKS_PER_COLUMN = 4,
  parameter int TRAVEL_ROWS        = 16,
  parameter int COLUMNS            = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  lmfs_pkg::in_item_t  in_item,
  input  lmfs_pkg::cmd_t      cmd,
  output lmfs_pkg::status_t   status,
  output logic                out_valid,
  input  logic                out_stall,
  output lmfs_pkg::out_item_t out_item
);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int LINE_W = STREAKS_PER_COLUMN * lmfs_pkg::POS_W;
  localparam logic [lmfs_pkg::POS_W:0] LIMIT =
    (lmfs_pkg::POS_W + 1)'(TRAVEL_ROWS + lmfs_pkg::TAIL_EXTRA);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

  logic [1:0]                  kind;
  logic [COL_W-1:0]            col;
  logic                        col_ok;
  logic [lmfs_pkg::MASK_W-1:0] mask;
  logic [lmfs_pkg::MASK_W-1:0] mask_next;
  logic [lmfs_pkg::ROW_W-1:0]  scan_row;
  logic [COLUMNS-1:0]          valid;

  logic [LINE_W-1:0] rdata;
  logic [LINE_W-1:0] line;
  logic [LINE_W-1:0] line_next;
  logic              hit;
  logic              we;

  lmfs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (COLUMNS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (col),
    .wdata (line_next),
    .raddr (col),
    .rdata (rdata)
  );

  // a column never written reads as all slots empty
  assign line = valid[col] ? rdata : '0;

  always_comb begin
    logic [lmfs_pkg::POS_W-1:0] p;
    logic [lmfs_pkg::POS_W-1:0] r0;
    logic                       placed;
    line_next = line;
    hit       = 1'b0;
    placed    = 1'b0;
    r0        = {1'b0, scan_row};
    for (int s = 0; s < STREAKS_PER_COLUMN; s++) begin
      p = line[s*lmfs_pkg::POS_W +: lmfs_pkg::POS_W];
      if (p != '0 && (p == r0 || p == r0 + 5'd1 || p == r0 + 5'd2)) begin
        hit = 1'b1;
      end
      if (kind == lmfs_pkg::KIND_ADVANCE) begin
        if (p != '0 && {1'b0, p} < LIMIT) begin
          line_next[s*lmfs_pkg::POS_W +: lmfs_pkg::POS_W] = p + 5'd1;
        end else begin
          line_next[s*lmfs_pkg::POS_W +: lmfs_pkg::POS_W] = '0;
        end
      end else if (p == '0 && !placed) begin
        line_next[s*lmfs_pkg::POS_W +: lmfs_pkg::POS_W] = 5'd1;
        placed = 1'b1;
      end
    end
  end

  assign we = cmd.work &&
              (kind == lmfs_pkg::KIND_ADVANCE || (kind == lmfs_pkg::KIND_SPAWN && col_ok));

  always_comb begin
    mask_next = mask;
    for (int j = 0; j < lmfs_pkg::MASK_W; j++) begin
      if (j < COLUMNS) begin
        if (hit && col == COL_W'(j)) begin
          mask_next[j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      scan_row  <= '0;
      out_valid <= 1'b0;
      kind      <= lmfs_pkg::KIND_SCAN;
    end else begin
      if (cmd.load) begin
        kind <= in_item.kind;
      end
      if (we) begin
        valid[col] <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        scan_row  <= scan_row + 4'd1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask   <= '0;
      col_ok <= ({1'b0, in_item.column} < 5'(COLUMNS));
      if (in_item.kind == lmfs_pkg::KIND_SPAWN) begin
        col <= in_item.column[COL_W-1:0];
      end else begin
        col <= '0;
      end
    end else begin
      if (cmd.work && kind == lmfs_pkg::KIND_SCAN) begin
        mask <= mask_next;
      end
      if (cmd.step) begin
        col <= col + COL_W'(1);
      end
    end
    if (cmd.finish) begin
      out_item.row_index   <= scan_row;
      out_item.column_mask <= mask;
      out_item.frame_end   <= (scan_row == lmfs_pkg::LAST_ROW);
    end
  end

  assign status.kind     = kind;
  assign status.last_col = (col == LAST_COL);
  assign status.out_free = !out_valid || !out_stall;
endmodule

FILE: rtl/core/led_matrix_falling_streaks_unit.sv
`timescale 1ns / 1ps
// channel | handshake            | payload
// input   | in_valid / in_stall  | in_item  (kind, column)
// output  | out_valid / out_stall| out_item (row_index, column_mask, frame_end)
//
// Spawn reads and works on its one column; advance and scan read and work on each column in turn.
// Column lines are read from the slot RAM; advance and an in-range spawn write them back.
// Synchronous reset empties every column through per-column valid bits, no clearing pass.
// A finished scan result waits in the output register while the next item is taken;
// a further scan holds before its output transfer until that register frees up.
module led_matrix_falling_streaks_unit #(
  parameter int STREAKS_PER_COLUMN = 4,
  parameter int TRAVEL_ROWS        = 16,
  parameter int COLUMNS            = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lmfs_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lmfs_pkg::out_item_t out_item
);
  lmfs_pkg::cmd_t    cmd;
  lmfs_pkg::status_t status;

  lmfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lmfs_datapath #(
    .STREAKS_PER_COLUMN (STREAKS_PER_COLUMN),
    .TRAVEL_ROWS        (TRAVEL_ROWS),
    .COLUMNS            (COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );
endmodule

FILE: tb/led_matrix_falling_streaks_unit_test.sv
`timescale 1ns / 1ps
module led_matrix_falling_streaks_unit_test;

  localparam int STREAK_SLOTS = 4;
  localparam int TRAVEL = 16;
  localparam int COLS = 16;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;

  class streak_scoreboard;
    logic [lmfs_pkg::POS_W-1:0] head_pos [COLS][STREAK_SLOTS];
    logic [lmfs_pkg::ROW_W-1:0] row_ctr;
    lmfs_pkg::out_item_t pending_rows[$];
    int errors;

    function new();
      foreach (head_pos[c, s]) head_pos[c][s] = '0;
      row_ctr = '0;
      errors = 0;
    endfunction

    function bit idle();
      return pending_rows.size() == 0;
    endfunction

    function void note_input(lmfs_pkg::in_item_t item);
      lmfs_pkg::out_item_t res;
      int row;
      bit placed;
      case (item.kind)
        lmfs_pkg::KIND_ADVANCE: begin
          foreach (head_pos[c, s]) begin
            if (head_pos[c][s] != 0 &&
                int'(head_pos[c][s]) < TRAVEL + lmfs_pkg::TAIL_EXTRA)
              head_pos[c][s] = head_pos[c][s] + lmfs_pkg::POS_W'(1);
            else
              head_pos[c][s] = '0;
          end
        end
        lmfs_pkg::KIND_SPAWN: begin
          placed = 1'b0;
          if (int'(item.column) < COLS) begin
            for (int s = 0; s < STREAK_SLOTS; s++) begin
              if (!placed && head_pos[item.column][s] == 0) begin
                head_pos[item.column][s] = lmfs_pkg::POS_W'(1);
                placed = 1'b1;
              end
            end
          end
        end
        lmfs_pkg::KIND_SCAN: begin
          row = int'(row_ctr);
          res.row_index = row_ctr;
          res.column_mask = '0;
          // light a column when a head sits on this row or up to two rows below
          foreach (head_pos[c, s]) begin
            if (head_pos[c][s] != 0 && int'(head_pos[c][s]) >= row &&
                int'(head_pos[c][s]) <= row + 2)
              res.column_mask[c] = 1'b1;
          end
          res.frame_end = (row_ctr == lmfs_pkg::LAST_ROW);
          pending_rows.push_back(res);
          row_ctr = row_ctr + lmfs_pkg::ROW_W'(1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(lmfs_pkg::out_item_t got);
      lmfs_pkg::out_item_t want;
      if (pending_rows.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending, expected none, got row %0d mask %h end %0b",
                 $time, got.row_index, got.column_mask, got.frame_end);
        return;
      end
      want = pending_rows.pop_front();
      if (got.row_index !== want.row_index) begin
        errors++;
        $display("%0t: bad row_index, expected %0d, got %0d",
                 $time, want.row_index, got.row_index);
      end
      if (got.column_mask !== want.column_mask) begin
        errors++;
        $display("%0t: bad column_mask on row %0d, expected %h, got %h",
                 $time, want.row_index, want.column_mask, got.column_mask);
      end
      if (got.frame_end !== want.frame_end) begin
        errors++;
        $display("%0t: bad frame_end on row %0d, expected %0b, got %0b",
                 $time, want.row_index, want.frame_end, got.frame_end);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  lmfs_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lmfs_pkg::out_item_t out_item;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycles = 0;
  streak_scoreboard sb;

  led_matrix_falling_streaks_unit #(
    .STREAKS_PER_COLUMN(STREAK_SLOTS),
    .TRAVEL_ROWS(TRAVEL),
    .COLUMNS(COLS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Enter and leave at a falling edge; valid stays high into the next item.
  task automatic send_item(input logic [1:0] kind, input logic [3:0] column);
    lmfs_pkg::in_item_t item;
    item.kind = kind;
    item.column = column;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (in_stall);
    sb.note_input(item);
    @(negedge clk);
  endtask

  // Hold off the sender until every pending row has come back.
  task automatic drain_rows();
    in_valid <= 1'b0;
    @(negedge clk);
    while (!sb.idle()) @(negedge clk);
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct);
    int pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (RANDOM_PER_PHASE) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send_item(lmfs_pkg::KIND_SCAN, 4'($urandom_range(15)));
      else if (pick < 75)
        send_item(lmfs_pkg::KIND_ADVANCE, 4'($urandom_range(15)));
      else if (pick < 95)
        send_item(lmfs_pkg::KIND_SPAWN, 4'($urandom_range(15)));
      else
        send_item(KIND_NONE, 4'($urandom_range(15)));
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 29;
    recv_idle_pct = 45;
    // empty slots must not light row 0
    send_item(lmfs_pkg::KIND_SCAN, 4'd0);
    send_item(KIND_NONE, 4'd15);
    // fifth spawn finds the column full and is dropped
    repeat (5) send_item(lmfs_pkg::KIND_SPAWN, 4'd0);
    send_item(lmfs_pkg::KIND_ADVANCE, 4'd0);
    send_item(lmfs_pkg::KIND_SPAWN, 4'd15);
    // a full frame, ending on the wrap
    repeat (16) send_item(lmfs_pkg::KIND_SCAN, 4'hf);
    drain_rows();

    random_phase(29, 45);
    drain_rows();
    random_phase(45, 29);
    drain_rows();
    random_phase(0, 0);
    drain_rows();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.idle())
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
